### design/ifir_pkg.sv
// Shared types and constants for the interpolating FIR filter.
// Used by ifir_cell, ifir_mac and interpolating_fir_filter; depends on nothing.
package ifir_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int MAX_TAPS    = 16;
  localparam int MAX_INTERP  = 8;
  localparam int STORE_DEPTH = MAX_TAPS * MAX_INTERP;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int TAP_IDX_W   = $clog2(MAX_TAPS);
  localparam int PHASE_W     = $clog2(MAX_INTERP);
  localparam int INTERP_W    = 4;
  localparam int NTAPS_W     = 5;
  localparam int PROD_W      = SAMPLE_W + COEF_W;
  localparam int ACC_W       = PROD_W + TAP_IDX_W;
  localparam int FRAC_W      = 15;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_INTERP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS   = 2'd1;

  localparam logic [INTERP_W-1:0] INTERP_RESET = 4'd4;
  localparam logic [NTAPS_W-1:0]  TAPS_RESET   = 5'd11;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // One tap of one phase, handed from the sequencer to the MAC.
  typedef struct packed {
    logic                       valid;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] tap;
    logic                       use_tap;
    logic                       first;
    logic                       last;
    logic                       last_phase;
  } tap_req_t;

  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] value;
    logic                       last_phase;
  } mac_res_t;

endpackage

### design/ifir_cell.sv
// One delay-line cell: a sample register loaded from its left neighbor.
// Depends on ifir_pkg for the sample width.
module ifir_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic signed [ifir_pkg::SAMPLE_W-1:0] d,
  output logic signed [ifir_pkg::SAMPLE_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (en) begin
      q <= d;
    end
  end

endmodule

### design/ifir_mac.sv
// Coefficient store and the multiply-accumulate pipeline with rounding and
// saturation. Depends on ifir_pkg for widths and the request/result structs.
module ifir_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 coef_we,
  input  logic [ifir_pkg::ADDR_W-1:0]          coef_waddr,
  input  logic signed [ifir_pkg::COEF_W-1:0]   coef_wdata,
  input  ifir_pkg::tap_req_t                   req,
  output ifir_pkg::mac_res_t                   res
);

  localparam int Q_W = ifir_pkg::ACC_W - ifir_pkg::FRAC_W;

  logic signed [ifir_pkg::COEF_W-1:0] coef_mem [ifir_pkg::STORE_DEPTH];

  logic                                 s1_valid;
  logic signed [ifir_pkg::COEF_W-1:0]   coef_q;
  logic signed [ifir_pkg::SAMPLE_W-1:0] tap_q;
  logic                                 use_q;
  logic                                 first_q;
  logic                                 last_q;
  logic                                 lph_q;

  logic                                 s2_valid;
  logic signed [ifir_pkg::PROD_W-1:0]   prod;
  logic                                 first2;
  logic                                 last2;
  logic                                 lph2;

  logic                                 s3_done;
  logic signed [ifir_pkg::ACC_W-1:0]    acc;
  logic                                 lph3;

  logic signed [ifir_pkg::ACC_W-1:0]    rnd;
  logic signed [Q_W-1:0]                q_val;
  logic                                 ovf;
  logic signed [ifir_pkg::SAMPLE_W-1:0] sat_val;

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    if (req.valid) begin
      coef_q <= coef_mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_done  <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      s1_valid  <= req.valid;
      s2_valid  <= s1_valid;
      s3_done   <= s2_valid && last2;
      res.valid <= s3_done;
    end
    res.value      <= sat_val;
    res.last_phase <= lph3;
  end

  always_ff @(posedge clk) begin
    tap_q   <= req.tap;
    use_q   <= req.use_tap;
    first_q <= req.first;
    last_q  <= req.last;
    lph_q   <= req.last_phase;

    // Taps past the branch length contribute nothing, whatever the store holds.
    if (use_q) begin
      prod <= tap_q * coef_q;
    end else begin
      prod <= '0;
    end
    first2 <= first_q;
    last2  <= last_q;
    lph2   <= lph_q;

    if (s2_valid) begin
      acc <= first2 ? ifir_pkg::ACC_W'(prod) : acc + ifir_pkg::ACC_W'(prod);
    end
    lph3 <= lph2;
  end

  // Round half up to Q15: add half an LSB, then take the floor by an
  // arithmetic shift.
  always_comb begin
    rnd     = acc + ifir_pkg::ACC_W'(1 << (ifir_pkg::FRAC_W - 1));
    q_val   = rnd[ifir_pkg::ACC_W-1:ifir_pkg::FRAC_W];
    ovf     = (q_val[Q_W-1:ifir_pkg::SAMPLE_W-1] != '0) &&
              (q_val[Q_W-1:ifir_pkg::SAMPLE_W-1] != '1);
    if (ovf) begin
      sat_val = q_val[Q_W-1] ? {1'b1, {(ifir_pkg::SAMPLE_W-1){1'b0}}}
                             : {1'b0, {(ifir_pkg::SAMPLE_W-1){1'b1}}};
    end else begin
      sat_val = q_val[ifir_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

### design/interpolating_fir_filter.sv
// Interpolating FIR filter: a ring of delay-line cells, the sequencer that
// rotates it and the MAC. Depends on ifir_pkg, ifir_cell and ifir_mac.
//
// Usage:
// The input channel (in_valid/in_ready) carries one command per transaction.
// cmd = 0 shifts sample_in into a 16-cell delay line and starts one output
// per phase; cmd = 1 writes coef_value at coef_index of the tap store and
// produces no output. The output channel (out_valid/out_ready) carries
// sample_out and last_phase, which marks the last output of a run.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets
// the interpolation factor (index 0) and the taps per branch (index 1); it
// is always ready and should be written only while no run is in progress.
// Each phase rotates the whole delay-line ring once, one tap per cycle once
// its first tap has issued, with one read of the single-port tap store per
// tap; each output then passes the coefficient read, product, accumulator,
// MAC result and output registers in that order.
// A new sample or tap word is taken as soon as the previous run has issued
// all its taps, while its last outputs may still wait in the pipeline.
// When the receiver stalls, the next phase waits until the held output is
// taken. Reset clears the delay line to zero and restores the registers to
// interp_factor = 4 and 11 taps; the tap store keeps no reset value.
module interpolating_fir_filter (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   cmd,
  input  logic signed [ifir_pkg::SAMPLE_W-1:0]   sample_in,
  input  logic [ifir_pkg::ADDR_W-1:0]            coef_index,
  input  logic signed [ifir_pkg::COEF_W-1:0]     coef_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [ifir_pkg::SAMPLE_W-1:0]   sample_out,
  output logic                                   last_phase,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ifir_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ifir_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam logic [ifir_pkg::TAP_IDX_W-1:0] LAST_STEP = '1;

  ifir_pkg::state_t state, state_next;
  logic [ifir_pkg::TAP_IDX_W-1:0] step, step_next;
  logic [ifir_pkg::PHASE_W-1:0]   phase, phase_next;

  logic [ifir_pkg::INTERP_W-1:0] interp_raw;
  logic [ifir_pkg::NTAPS_W-1:0]  taps_raw;
  logic [ifir_pkg::INTERP_W-1:0] sps;
  logic [ifir_pkg::NTAPS_W-1:0]  ntaps;

  logic res_pending;
  logic issue;
  logic shift_in;
  logic in_xact;
  logic out_xact;
  logic phase_done;

  logic signed [ifir_pkg::SAMPLE_W-1:0] ring [ifir_pkg::MAX_TAPS];
  logic signed [ifir_pkg::SAMPLE_W-1:0] cell0_d;

  logic [ifir_pkg::TAP_IDX_W-1:0] tap_m;
  logic [2*ifir_pkg::INTERP_W-1:0] m_times_sps;

  ifir_pkg::tap_req_t req;
  ifir_pkg::mac_res_t res;

  assign in_xact  = in_valid && in_ready;
  assign out_xact = out_valid && out_ready;
  assign cfg_ready = 1'b1;

  // Configuration registers, clamped into their legal ranges on use.
  always_ff @(posedge clk) begin
    if (rst) begin
      interp_raw <= ifir_pkg::INTERP_RESET;
      taps_raw   <= ifir_pkg::TAPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ifir_pkg::REG_INTERP: interp_raw <= cfg_data[ifir_pkg::INTERP_W-1:0];
        ifir_pkg::REG_TAPS:   taps_raw   <= cfg_data[ifir_pkg::NTAPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (interp_raw == '0) begin
      sps = ifir_pkg::INTERP_W'(1);
    end else if (interp_raw > ifir_pkg::INTERP_W'(ifir_pkg::MAX_INTERP)) begin
      sps = ifir_pkg::INTERP_W'(ifir_pkg::MAX_INTERP);
    end else begin
      sps = interp_raw;
    end
    if (taps_raw == '0) begin
      ntaps = ifir_pkg::NTAPS_W'(1);
    end else if (taps_raw > ifir_pkg::NTAPS_W'(ifir_pkg::MAX_TAPS)) begin
      ntaps = ifir_pkg::NTAPS_W'(ifir_pkg::MAX_TAPS);
    end else begin
      ntaps = taps_raw;
    end
  end

  // Sequencer: one phase is 16 ring rotations; a phase starts only once the
  // previous output has left the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ifir_pkg::ST_IDLE;
      step  <= '0;
      phase <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      phase <= phase_next;
    end
  end

  assign phase_done = ({1'b0, phase} == sps - ifir_pkg::INTERP_W'(1));

  always_comb begin
    state_next = state;
    step_next  = step;
    phase_next = phase;
    in_ready   = 1'b0;
    issue      = 1'b0;
    shift_in   = 1'b0;
    case (state)
      ifir_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && cmd == ifir_pkg::CMD_SAMPLE) begin
          shift_in   = 1'b1;
          phase_next = '0;
          step_next  = '0;
          state_next = ifir_pkg::ST_RUN;
        end
      end
      ifir_pkg::ST_RUN: begin
        issue = (step != '0) || !res_pending;
        if (issue) begin
          step_next = step + ifir_pkg::TAP_IDX_W'(1);
          if (step == LAST_STEP) begin
            if (phase_done) begin
              state_next = ifir_pkg::ST_IDLE;
            end else begin
              phase_next = phase + ifir_pkg::PHASE_W'(1);
            end
          end
        end
      end
      default: begin
        state_next = ifir_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_pending <= 1'b0;
    end else if (issue && step == '0) begin
      res_pending <= 1'b1;
    end else if (out_xact) begin
      res_pending <= 1'b0;
    end
  end

  // Delay-line ring. A new sample enters at cell 0; during a phase the last
  // cell wraps back to cell 0, so 16 rotations restore the line.
  assign cell0_d = issue ? ring[ifir_pkg::MAX_TAPS-1] : sample_in;

  for (genvar i = 0; i < ifir_pkg::MAX_TAPS; i++) begin : g_cell
    if (i == 0) begin : g_head
      ifir_cell u_cell (
        .clk (clk),
        .rst (rst),
        .en  (shift_in || issue),
        .d   (cell0_d),
        .q   (ring[i])
      );
    end else begin : g_body
      ifir_cell u_cell (
        .clk (clk),
        .rst (rst),
        .en  (shift_in || issue),
        .d   (ring[i-1]),
        .q   (ring[i])
      );
    end
  end

  // At rotation step k the last cell holds the sample of tap 15 - k.
  assign tap_m       = ~step;
  assign m_times_sps = {{ifir_pkg::INTERP_W{1'b0}}, tap_m} *
                       {{ifir_pkg::INTERP_W{1'b0}}, sps};

  always_comb begin
    req.valid      = issue;
    req.addr       = ifir_pkg::ADDR_W'(m_times_sps) + ifir_pkg::ADDR_W'(phase);
    req.tap        = ring[ifir_pkg::MAX_TAPS-1];
    req.use_tap    = ({1'b0, tap_m} < ntaps);
    req.first      = (step == '0);
    req.last       = (step == LAST_STEP);
    req.last_phase = phase_done;
  end

  ifir_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .coef_we    (in_xact && cmd == ifir_pkg::CMD_COEF),
    .coef_waddr (coef_index),
    .coef_wdata (coef_value),
    .req        (req),
    .res        (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (out_xact) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      sample_out <= res.value;
      last_phase <= res.last_phase;
    end
  end

`ifndef SYNTHESIS
  a_out_pending : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> res_pending)
    else $error("output held without a pending phase");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !out_valid)
    else $error("MAC result arrived while the output register was full");

  a_idle_aligned : assert property (@(posedge clk) disable iff (rst)
    state == ifir_pkg::ST_IDLE |-> step == '0)
    else $error("ring left unaligned at the end of a run");
`endif

endmodule
